@@ rtl/core/itf_pkg.sv @@
`default_nettype none
package itf_pkg;

    // radix codes on base_sel
    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    // format_flags bit positions
    localparam int FL_ZERO  = 0;
    localparam int FL_LEFT  = 1;
    localparam int FL_PLUS  = 2;
    localparam int FL_SPACE = 3;
    localparam int FL_ALT   = 4;
    localparam int FL_UPPER = 5;
    localparam int FL_PREC  = 6;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // 12-bit value / 10 by reciprocal: (v * 6554) >> 16, exact for v < 2560
    localparam logic [12:0] RECIP10 = 13'd6554;

    typedef struct packed {
        logic       start;
        logic [1:0] base_sel;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [3:0] digit;
    } t_div_rsp;

endpackage
`default_nettype wire

@@ rtl/core/itf_div_unit.sv @@
`default_nettype none
module itf_div_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire itf_pkg::t_div_req i_req,
    input  wire logic [63:0]      i_value,
    output itf_pkg::t_div_rsp     o_rsp,
    output logic [63:0]           o_quot
);
    import itf_pkg::*;

    logic [63:0] r_q;
    logic [3:0]  r_rem;
    logic [3:0]  r_digit;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    // one byte of the dividend per step, remainder carried down
    logic [11:0] step_v;
    logic [24:0] step_prod;
    logic [7:0]  step_q;
    logic [11:0] step_q10;
    logic [3:0]  step_r;

    // power-of-two radix: mask and shift
    logic [5:0]  p2_sh;
    logic [3:0]  p2_mask;

    assign step_v    = {r_rem, r_q[63:56]};
    assign step_prod = 25'(step_v) * 25'(RECIP10);
    assign step_q    = step_prod[23:16];
    assign step_q10  = {1'b0, step_q, 3'b000} + {3'b000, step_q, 1'b0};
    assign step_r    = 4'(step_v - step_q10);

    always_comb begin
        case (i_req.base_sel)
            BASE_BIN: begin p2_sh = 6'd1; p2_mask = 4'h1; end
            BASE_OCT: begin p2_sh = 6'd3; p2_mask = 4'h7; end
            default:  begin p2_sh = 6'd4; p2_mask = 4'hf; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.base_sel == BASE_DEC) begin
                    r_q    <= i_value;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end else begin
                    r_q     <= i_value >> p2_sh;
                    r_digit <= i_value[3:0] & p2_mask;
                    r_done  <= 1'b1;
                end
            end else if (r_busy) begin
                r_q   <= {r_q[55:0], step_q};
                r_rem <= step_r;
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_digit <= step_r;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.digit = r_digit;
    assign o_quot      = r_q;

endmodule
`default_nettype wire

@@ rtl/core/integer_to_text_formatter_core.sv @@
`default_nettype none
// printf-style integer formatter. Each input beat carries a 64-bit magnitude,
// sign, radix, precision, width and flags; the block then streams the field
// out one character per output beat, last_char marking the final one (a zero
// value with explicit precision of zero, no width and no sign gives no beats
// at all). Digits come from one divide unit, by mask and shift for binary,
// octal and hex and, for decimal, by a start step, eight byte-wide reciprocal
// steps and a step that takes the digit. Precision zeros, zero padding,
// prefix and sign are written to the digit buffer one character at a time,
// then the field drains at one character per cycle while the output is not
// stalled, up to 64 beats. No new input beat is taken until the last
// character of the field has gone.
module integer_to_text_formatter_core #(
    parameter int DIGIT_BUFFER = 32,
    parameter int MAX_WIDTH    = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_magnitude,
    input  wire logic        i_negative,
    input  wire logic [1:0]  i_base_sel,
    input  wire logic [5:0]  i_precision,
    input  wire logic [6:0]  i_field_width,
    input  wire logic [6:0]  i_format_flags,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_char_code,
    output logic             o_last_char
);
    import itf_pkg::*;

    localparam int LENW = $clog2(DIGIT_BUFFER + 1);
    localparam int LW   = $clog2(DIGIT_BUFFER);
    localparam logic [LENW-1:0] DB_LEN  = LENW'(DIGIT_BUFFER);
    localparam logic [LENW-1:0] DB_LAST = LENW'(DIGIT_BUFFER - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DGO, S_DWAIT, S_FILL, S_ALT, S_PFX1, S_PFX2, S_SIGN,
        S_SETUP, S_EMIT
    } t_state;

    t_state      r_state;
    logic [63:0] r_mag;
    logic        r_neg;
    logic [1:0]  r_base;
    logic [5:0]  r_prec;
    logic [6:0]  r_w;
    logic [6:0]  r_fl;
    logic [LENW-1:0] r_len;
    logic [6:0]  r_padl;
    logic [6:0]  r_rem;
    logic [7:0]  r_buf [DIGIT_BUFFER];
    logic        r_out_valid;
    logic [7:0]  r_char;
    logic        r_last;

    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic [63:0] div_quot;

    itf_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_value (r_mag),
        .o_rsp   (div_rsp),
        .o_quot  (div_quot)
    );

    assign div_req.start    = (r_state == S_DGO);
    assign div_req.base_sel = r_base;

    // capture-side decode
    logic [6:0] in_wsat;
    logic [6:0] in_w;
    logic       in_zero_val;
    logic [6:0] in_fl;

    assign in_wsat     = (i_field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : i_field_width;
    assign in_zero_val = (i_magnitude == 64'd0);

    always_comb begin
        in_fl = i_format_flags;
        if (in_zero_val) in_fl[FL_ALT] = 1'b0;
        in_w = in_wsat;
        // room for the sign when zero padding right-justified
        if (!i_format_flags[FL_LEFT] && in_wsat != 7'd0 && i_format_flags[FL_ZERO] &&
            (i_negative || i_format_flags[FL_PLUS] || i_format_flags[FL_SPACE]))
            in_w = in_wsat - 7'd1;
    end

    // working-side decode
    logic [7:0] len8;
    logic [7:0] prec8;
    logic [7:0] w8;
    logic       room;
    logic [7:0] dig_ch;
    logic [LENW-1:0] len_m1;
    logic [LENW-1:0] len_trim;
    logic       has_sign;
    logic [7:0] sign_ch;
    logic       padded;
    logic [6:0] len7;
    logic [6:0] excess;

    assign len8  = 8'(r_len);
    assign prec8 = 8'(r_prec);
    assign w8    = 8'(r_w);
    assign room  = (r_len < DB_LEN);
    assign len7  = 7'(r_len);

    always_comb begin
        if (div_rsp.digit < 4'd10)
            dig_ch = CH_ZERO + 8'(div_rsp.digit);
        else
            dig_ch = (r_fl[FL_UPPER] ? CH_UA : CH_LA) + 8'(div_rsp.digit - 4'd10);
    end

    // alternate-form trimming: one character, two for hex
    assign len_m1   = r_len - LENW'(1);
    assign len_trim = (len_m1 != '0 && r_base == BASE_HEX) ? len_m1 - LENW'(1) : len_m1;

    assign has_sign = r_neg || r_fl[FL_PLUS] || r_fl[FL_SPACE];
    assign sign_ch  = r_neg ? CH_MINUS : (r_fl[FL_PLUS] ? CH_PLUS : CH_SPACE);

    assign padded = r_fl[FL_LEFT] || !r_fl[FL_ZERO];
    assign excess = (r_w > len7) ? (r_w - len7) : 7'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
            r_len       <= '0;
            r_padl      <= '0;
            r_rem       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mag  <= i_magnitude;
                        r_neg  <= i_negative;
                        r_base <= i_base_sel;
                        r_prec <= i_precision;
                        r_w    <= in_w;
                        r_fl   <= in_fl;
                        r_len  <= '0;
                        if (i_format_flags[FL_PREC] && in_zero_val)
                            r_state <= S_FILL;
                        else
                            r_state <= S_DGO;
                    end
                end
                S_DGO: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        r_buf[r_len[LW-1:0]] <= dig_ch;
                        r_len <= r_len + LENW'(1);
                        r_mag <= div_quot;
                        if (div_quot == 64'd0 || r_len == DB_LAST)
                            r_state <= S_FILL;
                        else
                            r_state <= S_DGO;
                    end
                end
                S_FILL: begin
                    if (r_fl[FL_LEFT]) begin
                        r_state <= S_ALT;
                    end else if (room && (len8 < prec8 ||
                                          (r_fl[FL_ZERO] && len8 < w8))) begin
                        r_buf[r_len[LW-1:0]] <= CH_ZERO;
                        r_len <= r_len + LENW'(1);
                    end else begin
                        r_state <= S_ALT;
                    end
                end
                S_ALT: begin
                    if (!r_fl[FL_ALT]) begin
                        r_state <= S_SIGN;
                    end else begin
                        if (!r_fl[FL_PREC] && r_len != '0 && (len8 == prec8 || len8 == w8))
                            r_len <= len_trim;
                        r_state <= S_PFX1;
                    end
                end
                S_PFX1: begin
                    if (room && r_base == BASE_HEX) begin
                        r_buf[r_len[LW-1:0]] <= r_fl[FL_UPPER] ? CH_UX : CH_LX;
                        r_len <= r_len + LENW'(1);
                    end else if (room && r_base == BASE_BIN) begin
                        r_buf[r_len[LW-1:0]] <= CH_LB;
                        r_len <= r_len + LENW'(1);
                    end
                    r_state <= S_PFX2;
                end
                S_PFX2: begin
                    if (room) begin
                        r_buf[r_len[LW-1:0]] <= CH_ZERO;
                        r_len <= r_len + LENW'(1);
                    end
                    r_state <= S_SIGN;
                end
                S_SIGN: begin
                    if (room && has_sign) begin
                        r_buf[r_len[LW-1:0]] <= sign_ch;
                        r_len <= r_len + LENW'(1);
                    end
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_padl  <= (!r_fl[FL_LEFT] && !r_fl[FL_ZERO]) ? excess : 7'd0;
                    r_rem   <= padded ? (len7 + excess) : len7;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        if (r_rem != 7'd0) begin
                            r_out_valid <= 1'b1;
                            r_last      <= (r_rem == 7'd1);
                            r_rem       <= r_rem - 7'd1;
                            if (r_padl != 7'd0) begin
                                r_char <= CH_SPACE;
                                r_padl <= r_padl - 7'd1;
                            end else if (r_len != '0) begin
                                r_char <= r_buf[len_m1[LW-1:0]];
                                r_len  <= len_m1;
                            end else begin
                                r_char <= CH_SPACE;
                            end
                        end else begin
                            r_out_valid <= 1'b0;
                            r_last      <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

endmodule
`default_nettype wire
